// ===== hdl/kpsdr_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad scanner package
// Shared types, constants and helper functions for the keypad scanner with
// debounce, auto-repeat and event ring.
// ----------------------------------------------------------------------------
package kpsdr_pkg;

    // Matrix geometry and storage sizes.
    localparam int ROWS         = 7;
    localparam int COLUMNS      = 5;
    localparam int RING_SLOTS   = 8;
    localparam int RING_AW      = $clog2(RING_SLOTS);
    localparam int RING_CW      = $clog2(RING_SLOTS + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int SAMPLE_W     = 35;
    localparam int RAW_W        = 8;
    localparam int QUEUED_W     = 3;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;

    // Command codes on the input channel.
    typedef enum logic [1:0] {
        CMD_SCAN      = 2'd0,
        CMD_POLL      = 2'd1,
        CMD_CLEAR     = 2'd2,
        CMD_SET_SHIFT = 2'd3
    } cmd_t;

    // Event kinds.
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_PRESS   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_REPEAT  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RELOAD    = 2'd3;

    // Configuration reset values.
    localparam logic [3:0]  DEBOUNCE_RESET  = 4'd3;
    localparam logic [15:0] STEP_RESET      = 16'd10;
    localparam logic [15:0] THRESHOLD_RESET = 16'd500;
    localparam logic [15:0] RELOAD_RESET    = 16'd400;

    // The key that toggles the shift state.
    localparam logic [2:0] SHIFT_KEY_ROW    = 3'd6;
    localparam logic [2:0] SHIFT_KEY_COLUMN = 3'd1;

    // Classified item passed from the front end to the back end.
    typedef struct packed {
        cmd_t             cmd;
        logic [RAW_W-1:0] raw;
        logic             shift_value;
    } item_t;

    // One entry of the event ring.
    typedef struct packed {
        logic       shifted;
        logic [2:0] column;
        logic [2:0] row;
        logic [1:0] kind;
    } event_t;

    // One result word.
    typedef struct packed {
        logic                event_valid;
        logic [1:0]          event_kind;
        logic [2:0]          key_row;
        logic [2:0]          key_column;
        logic                key_shifted;
        logic                shift_now;
        logic                activity;
        logic [QUEUED_W-1:0] queued;
    } result_t;

    // Lowest set column of a raw code, zero when none is set.
    function automatic logic [2:0] lowest_column(input logic [RAW_W-1:0] raw);
        logic [2:0] col;
        col = 3'd0;
        for (int c = 4; c >= 0; c--) begin
            if (raw[c]) begin
                col = 3'(c);
            end
        end
        return col;
    endfunction

    // Build a ring entry from a raw code.
    function automatic event_t make_event(input logic [1:0] kind,
                                          input logic [RAW_W-1:0] raw,
                                          input logic shifted);
        event_t ev;
        ev.kind    = kind;
        ev.row     = raw[7:5];
        ev.column  = lowest_column(raw);
        ev.shifted = shifted;
        return ev;
    endfunction

    // Ring pointer advance with wrap.
    function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] ptr);
        return (ptr == RING_AW'(RING_SLOTS - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // Number of entries between tail and head.
    function automatic logic [RING_CW-1:0] ring_count(input logic [RING_AW-1:0] head,
                                                      input logic [RING_AW-1:0] tail);
        logic [RING_CW-1:0] h;
        logic [RING_CW-1:0] t;
        h = RING_CW'(head);
        t = RING_CW'(tail);
        return (head >= tail) ? (h - t) : (h + RING_CW'(RING_SLOTS) - t);
    endfunction

endpackage

// ===== hdl/kpsdr_front.sv =====
// ----------------------------------------------------------------------------
// Keypad scanner front end
// Classifies an input word: finds the first row with any column set and
// forms the raw key code that the back end works on.
// ----------------------------------------------------------------------------
module kpsdr_front (
    input  logic [1:0]                   cmd,
    input  logic [kpsdr_pkg::SAMPLE_W-1:0] matrix_sample,
    input  logic                         shift_value,
    output kpsdr_pkg::item_t             item
);
    import kpsdr_pkg::*;

    logic [RAW_W-1:0] raw;

    // Priority encode over rows; the lowest row with a set column wins.
    always_comb begin
        raw = '0;
        for (int r = ROWS - 1; r >= 0; r--) begin
            if (matrix_sample[r*5 +: COLUMNS] != '0) begin
                raw = {3'(r), 5'(matrix_sample[r*5 +: COLUMNS])};
            end
        end
    end

    // Pack the classified item.
    always_comb begin
        item.cmd         = cmd_t'(cmd);
        item.raw         = raw;
        item.shift_value = shift_value;
    end

endmodule

// ===== hdl/kpsdr_queue.sv =====
// ----------------------------------------------------------------------------
// Keypad scanner item queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module kpsdr_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  kpsdr_pkg::item_t push_item,
    output logic             not_full,
    input  logic             pop,
    output kpsdr_pkg::item_t pop_item,
    output logic             not_empty
);
    import kpsdr_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    item_t          slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    assign not_full  = (count_reg != QCW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/kpsdr_back.sv =====
// ----------------------------------------------------------------------------
// Keypad scanner back end
// Debounce, auto-repeat, shift toggle and the event ring; holds the
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module kpsdr_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_write,
    input  logic [kpsdr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kpsdr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            q_valid,
    input  kpsdr_pkg::item_t                q_item,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output kpsdr_pkg::result_t              out_result
);
    import kpsdr_pkg::*;

    // Configuration.
    logic [3:0]  debounce_reg;
    logic [15:0] step_reg;
    logic [15:0] threshold_reg;
    logic [15:0] reload_reg;

    // Scanner state.
    logic [RAW_W-1:0]   prev_raw_reg, prev_raw_next;
    logic [RAW_W-1:0]   stable_raw_reg, stable_raw_next;
    logic [3:0]         settle_reg, settle_next;
    logic [15:0]        repeat_reg, repeat_next;
    logic               shift_reg, shift_next;
    logic [RING_AW-1:0] head_reg, head_next;
    logic [RING_AW-1:0] tail_reg, tail_next;
    event_t             ring_reg [RING_SLOTS];

    // Output stage.
    logic    out_valid_reg, out_valid_next;
    result_t result_reg, result_next;

    logic        enq;
    event_t      enq_word;
    event_t      tail_word;
    logic [3:0]  settle_inc;
    logic [16:0] repeat_sum;
    logic [15:0] repeat_sat;
    logic        shift_key;

    assign q_pop      = q_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;
    assign tail_word  = ring_reg[tail_reg];

    // Counter arithmetic for a repeated raw code.
    assign settle_inc = (settle_reg < debounce_reg) ? settle_reg + 1'b1 : settle_reg;
    assign repeat_sum = {1'b0, repeat_reg} + {1'b0, step_reg};
    assign repeat_sat = repeat_sum[16] ? 16'hFFFF : repeat_sum[15:0];
    assign shift_key  = (q_item.raw[7:5] == SHIFT_KEY_ROW)
                     && (lowest_column(q_item.raw) == SHIFT_KEY_COLUMN);

    // Execute one item.
    always_comb begin
        prev_raw_next   = prev_raw_reg;
        stable_raw_next = stable_raw_reg;
        settle_next     = settle_reg;
        repeat_next     = repeat_reg;
        shift_next      = shift_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        enq             = 1'b0;
        enq_word        = '0;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if (q_pop) begin
            result_next    = '0;
            out_valid_next = 1'b1;
            unique case (q_item.cmd)
                CMD_SCAN: begin
                    if (q_item.raw != prev_raw_reg) begin
                        result_next.activity = 1'b1;
                        settle_next          = '0;
                        prev_raw_next        = q_item.raw;
                    end else begin
                        settle_next = settle_inc;
                        if (settle_inc >= debounce_reg) begin
                            if (stable_raw_reg != q_item.raw) begin
                                enq = 1'b1;
                                if (q_item.raw != '0) begin
                                    enq_word    = make_event(KIND_PRESS, q_item.raw, shift_reg);
                                    repeat_next = '0;
                                    if (shift_key) begin
                                        shift_next = ~shift_reg;
                                    end
                                end else begin
                                    enq_word = make_event(KIND_RELEASE, stable_raw_reg,
                                                          shift_reg);
                                end
                                stable_raw_next = q_item.raw;
                            end else if (q_item.raw != '0) begin
                                repeat_next = repeat_sat;
                                if (repeat_sat >= threshold_reg) begin
                                    repeat_next = reload_reg;
                                    enq         = 1'b1;
                                    enq_word    = make_event(KIND_REPEAT, q_item.raw, shift_reg);
                                end
                            end
                        end
                    end
                end
                CMD_POLL: begin
                    if (head_reg != tail_reg) begin
                        result_next.event_valid = 1'b1;
                        result_next.event_kind  = tail_word.kind;
                        result_next.key_row     = tail_word.row;
                        result_next.key_column  = tail_word.column;
                        result_next.key_shifted = tail_word.shifted;
                        tail_next               = ring_inc(tail_reg);
                    end
                end
                CMD_CLEAR: begin
                    stable_raw_next = '0;
                    prev_raw_next   = '0;
                    settle_next     = '0;
                    shift_next      = 1'b0;
                    head_next       = '0;
                    tail_next       = '0;
                end
                CMD_SET_SHIFT: begin
                    shift_next = q_item.shift_value;
                end
                default: begin
                    shift_next = shift_reg;
                end
            endcase
            // Enqueue drops the oldest entry when the ring is full.
            if (enq) begin
                head_next = ring_inc(head_reg);
                if (ring_inc(head_reg) == tail_reg) begin
                    tail_next = ring_inc(tail_reg);
                end
            end
            result_next.shift_now = shift_next;
            result_next.queued    = QUEUED_W'(ring_count(head_next, tail_next));
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RESET;
            step_reg       <= STEP_RESET;
            threshold_reg  <= THRESHOLD_RESET;
            reload_reg     <= RELOAD_RESET;
            prev_raw_reg   <= '0;
            stable_raw_reg <= '0;
            settle_reg     <= '0;
            repeat_reg     <= '0;
            shift_reg      <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_DEBOUNCE:  debounce_reg  <= cfg_data[3:0];
                    REG_STEP:      step_reg      <= cfg_data;
                    REG_THRESHOLD: threshold_reg <= cfg_data;
                    REG_RELOAD:    reload_reg    <= cfg_data;
                    default:       reload_reg    <= reload_reg;
                endcase
            end
            prev_raw_reg   <= prev_raw_next;
            stable_raw_reg <= stable_raw_next;
            settle_reg     <= settle_next;
            repeat_reg     <= repeat_next;
            shift_reg      <= shift_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        result_reg <= result_next;
        if (enq) begin
            ring_reg[head_reg] <= enq_word;
        end
    end

`ifndef SYNTHESIS
    // A clear leaves an empty ring behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_item.cmd == CMD_CLEAR |=> result_reg.queued == '0)
        else $error("ring not empty after clear");

    // Only a poll can return an event.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_item.cmd != CMD_POLL |=> !result_reg.event_valid)
        else $error("event reported on a non-poll word");

    // A poll on a non-empty ring always returns an event.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_item.cmd == CMD_POLL && head_reg != tail_reg
        |=> result_reg.event_valid && result_reg.event_kind != KIND_NONE)
        else $error("poll missed a queued event");

    // Activity is only flagged for scans.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_item.cmd != CMD_SCAN |=> !result_reg.activity)
        else $error("activity flagged on a non-scan word");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(result_reg))
        else $error("stalled result changed");
`endif

endmodule

// ===== hdl/keypad_scan_debounce_repeat.sv =====
// ----------------------------------------------------------------------------
// Keypad scanner with debounce and auto-repeat
// Scans a 7x5 key matrix, debounces the key code, queues press, release and
// repeat events in an eight-slot ring and hands them out on poll words.
//
// Usage:
//   s_ channel: one word per command. s_tuser carries the command (scan,
//   poll, clear, set shift); s_tdata carries the matrix sample and the new
//   shift value. Every accepted word produces exactly one m_ word.
//   m_ channel: m_tuser carries the event flag and kind, m_tdata the key,
//   shift state, activity flag and ring fill count.
//   cfg_ channel: writes debounce count, repeat step, repeat threshold and
//   repeat reload by index; cfg_ready is always high. Write only while idle.
// Timing:
//   The result of an accepted word passes through the queue slot and the
//   back end's output register to m_. One word per cycle while m_ is not
//   stalled: the back end updates each word at once, behind a two-entry queue.
// Reset and stalls:
//   aresetn clears all scanner state and loads the register defaults
//   (3, 10, 500, 400). When m_tready is low the result holds, the back end
//   stops and the queue fills; s_tready falls once the queue is full.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_repeat (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [39:0]                       s_tdata,   // matrix_sample[34:0], shift_value[35]
    input  logic [1:0]                        s_tuser,   // cmd[1:0]
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // key_row[2:0], key_column[5:3],
                                                         // key_shifted[6], shift_now[7],
                                                         // activity[8], queued[11:9]
    output logic [2:0]                        m_tuser,   // event_valid[0], event_kind[2:1]
    // Configuration channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kpsdr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kpsdr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import kpsdr_pkg::*;

    item_t   front_item;
    item_t   q_item;
    logic    q_not_full;
    logic    q_not_empty;
    logic    q_pop;
    result_t result;

    assign cfg_ready = 1'b1;
    assign s_tready  = q_not_full;

    // Classification of the incoming word.
    kpsdr_front u_front (
        .cmd           (s_tuser),
        .matrix_sample (s_tdata[SAMPLE_W-1:0]),
        .shift_value   (s_tdata[SAMPLE_W]),
        .item          (front_item)
    );

    // Queue between front and back end.
    kpsdr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid && q_not_full),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .not_empty (q_not_empty)
    );

    // State update and output register.
    kpsdr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_write  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_valid    (q_not_empty),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Result packing.
    assign m_tuser = {result.event_kind, result.event_valid};
    assign m_tdata = {4'd0, result.queued, result.activity, result.shift_now,
                      result.key_shifted, result.key_column, result.key_row};

endmodule

// ===== bench/keypad_scan_debounce_repeat_tb.sv =====
// ----------------------------------------------------------------------------
// Keypad scanner testbench
// Drives scan, poll, clear and set-shift words into the keypad scanner under
// random stalls on both channels, predicts every result word with a cycle-free
// model of the debounce, auto-repeat and event ring, and compares each result
// field by field. The register settings change between phases, only while the
// block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_scan_debounce_repeat_tb;
    import kpsdr_pkg::*;

    // Predicts result words from accepted input words and checks the block's output.
    class keypad_predictor;
        // Register copies.
        logic [3:0]  debounce_count;
        logic [15:0] repeat_step;
        logic [15:0] repeat_threshold;
        logic [15:0] repeat_reload;
        // Scanner state.
        logic [7:0]  prior_code;
        logic [7:0]  settled_code;
        logic [3:0]  settle_cnt;
        logic [15:0] repeat_cnt;
        logic        shift_flag;
        event_t      ring [RING_SLOTS];
        logic [2:0]  wr_ptr;
        logic [2:0]  rd_ptr;
        // Results still owed by the block, oldest first.
        result_t     pending_results [$];
        // Statistics.
        int errors;
        int checked;
        int presses;
        int releases;
        int repeats;
        int drops;
        int polls_hit;
        int polls_empty;

        function new();
            debounce_count   = DEBOUNCE_RESET;
            repeat_step      = STEP_RESET;
            repeat_threshold = THRESHOLD_RESET;
            repeat_reload    = RELOAD_RESET;
            prior_code       = '0;
            settled_code     = '0;
            settle_cnt       = '0;
            repeat_cnt       = '0;
            shift_flag       = 1'b0;
            wr_ptr           = '0;
            rd_ptr           = '0;
            errors           = 0;
            checked          = 0;
            presses          = 0;
            releases         = 0;
            repeats          = 0;
            drops            = 0;
            polls_hit        = 0;
            polls_empty      = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DEBOUNCE:  debounce_count   = data[3:0];
                REG_STEP:      repeat_step      = data;
                REG_THRESHOLD: repeat_threshold = data;
                REG_RELOAD:    repeat_reload    = data;
                default: ;
            endcase
        endfunction

        function logic [2:0] first_column(logic [7:0] code);
            logic [2:0] col;
            col = 3'd0;
            for (int c = COLUMNS - 1; c >= 0; c--) begin
                if (code[c]) begin
                    col = 3'(c);
                end
            end
            return col;
        endfunction

        // Queue an event, dropping the oldest one when the ring is full.
        function void push_event(logic [1:0] kind, logic [7:0] code);
            event_t     ev;
            logic [2:0] next;
            next       = wr_ptr + 3'd1;
            ev.kind    = kind;
            ev.row     = code[7:5];
            ev.column  = first_column(code);
            ev.shifted = shift_flag;
            if (next == rd_ptr) begin
                rd_ptr = rd_ptr + 3'd1;
                drops++;
            end
            ring[wr_ptr] = ev;
            wr_ptr = next;
            case (kind)
                KIND_PRESS:   presses++;
                KIND_RELEASE: releases++;
                default:      repeats++;
            endcase
        endfunction

        // One scan: encode, debounce, then press, release or repeat.
        function logic scan(logic [SAMPLE_W-1:0] smp);
            logic [7:0]  code;
            logic [16:0] sum;
            logic        found;
            logic        act;
            code  = 8'd0;
            found = 1'b0;
            act   = 1'b0;
            for (int r = 0; r < ROWS; r++) begin
                if (!found && smp[r*COLUMNS +: COLUMNS] != '0) begin
                    code  = {3'(r), smp[r*COLUMNS +: COLUMNS]};
                    found = 1'b1;
                end
            end
            if (code != prior_code) begin
                act        = 1'b1;
                settle_cnt = '0;
                prior_code = code;
            end else begin
                if (settle_cnt < debounce_count) begin
                    settle_cnt = settle_cnt + 4'd1;
                end
                if (settle_cnt >= debounce_count) begin
                    if (settled_code != code) begin
                        if (code != 8'd0) begin
                            // The press carries the shift state from before the toggle.
                            push_event(KIND_PRESS, code);
                            if (code[7:5] == SHIFT_KEY_ROW
                                && first_column(code) == SHIFT_KEY_COLUMN) begin
                                shift_flag = ~shift_flag;
                            end
                            repeat_cnt = '0;
                        end else begin
                            push_event(KIND_RELEASE, settled_code);
                        end
                        settled_code = code;
                    end else if (code != 8'd0) begin
                        // Held key: saturating repeat accumulator.
                        sum = {1'b0, repeat_cnt} + {1'b0, repeat_step};
                        repeat_cnt = sum[16] ? 16'hFFFF : sum[15:0];
                        if (repeat_cnt >= repeat_threshold) begin
                            repeat_cnt = repeat_reload;
                            push_event(KIND_REPEAT, code);
                        end
                    end
                end
            end
            return act;
        endfunction

        // Work out the result of one accepted input word.
        function void note_word(cmd_t op, logic [SAMPLE_W-1:0] smp, logic shift_value);
            result_t want;
            event_t  ev;
            want = '0;
            case (op)
                CMD_SCAN: begin
                    want.activity = scan(smp);
                end
                CMD_POLL: begin
                    if (wr_ptr != rd_ptr) begin
                        ev = ring[rd_ptr];
                        rd_ptr = rd_ptr + 3'd1;
                        want.event_valid = 1'b1;
                        want.event_kind  = ev.kind;
                        want.key_row     = ev.row;
                        want.key_column  = ev.column;
                        want.key_shifted = ev.shifted;
                        polls_hit++;
                    end else begin
                        polls_empty++;
                    end
                end
                CMD_CLEAR: begin
                    // The repeat accumulator survives a clear.
                    settled_code = '0;
                    prior_code   = '0;
                    settle_cnt   = '0;
                    shift_flag   = 1'b0;
                    wr_ptr       = '0;
                    rd_ptr       = '0;
                end
                default: begin
                    shift_flag = shift_value;
                end
            endcase
            want.shift_now = shift_flag;
            want.queued    = wr_ptr - rd_ptr;
            pending_results.push_back(want);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        // Compare one result word with the oldest expectation.
        function void check_word(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("event_valid", want.event_valid, got.event_valid);
            compare_field("event_kind", want.event_kind, got.event_kind);
            compare_field("key_row", want.key_row, got.key_row);
            compare_field("key_column", want.key_column, got.key_column);
            compare_field("key_shifted", want.key_shifted, got.key_shifted);
            compare_field("shift_now", want.shift_now, got.shift_now);
            compare_field("activity", want.activity, got.activity);
            compare_field("queued", want.queued, got.queued);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [39:0]            s_tdata   = '0;
    logic [1:0]             s_tuser   = CMD_SCAN;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [15:0]            m_tdata;
    logic [2:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    keypad_predictor predictor = new();

    int words_sent    = 0;
    int settings_used = 1;
    bit src_gaps_on   = 1'b1;
    bit sink_gaps_on  = 1'b1;

    keypad_scan_debounce_repeat uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Sample with the given key pressed; rows below it carry random bits.
    function automatic logic [SAMPLE_W-1:0] key_sample(input int row, input logic [4:0] cols);
        logic [SAMPLE_W-1:0] smp;
        smp = SAMPLE_W'({$urandom, $urandom});
        for (int r = 0; r < ROWS; r++) begin
            if (r < row) begin
                smp[r*COLUMNS +: COLUMNS] = '0;
            end else if (r == row) begin
                smp[r*COLUMNS +: COLUMNS] = cols;
            end
        end
        return smp;
    endfunction

    // Offer one input word, with an occasional gap before it. Entered and left
    // at a falling edge.
    task automatic send_word(input cmd_t op, input logic [SAMPLE_W-1:0] smp, input logic sv);
        if (src_gaps_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, sv, smp};
        do @(posedge aclk); while (!s_tready);
        predictor.note_word(op, smp, sv);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        predictor.write_register(idx, data);
        @(negedge aclk);
    endtask

    // Hold the sender until every expected result has come.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (predictor.pending() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic load_settings(input logic [3:0] deb, input logic [15:0] step,
                                 input logic [15:0] thr, input logic [15:0] rel);
        wait_idle();
        cfg_write(REG_DEBOUNCE, {12'd0, deb});
        cfg_write(REG_STEP, step);
        cfg_write(REG_THRESHOLD, thr);
        cfg_write(REG_RELOAD, rel);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic hold_key(input int row, input logic [4:0] cols, input int scans);
        repeat (scans) send_word(CMD_SCAN, key_sample(row, cols), 1'($urandom));
    endtask

    // Now and then slip in a poll, a shift write, a clear or a noise scan.
    task automatic maybe_interject();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            send_word(CMD_POLL, SAMPLE_W'({$urandom, $urandom}), 1'($urandom));
        end else if (pick < 24) begin
            send_word(CMD_SET_SHIFT, SAMPLE_W'({$urandom, $urandom}), 1'($urandom));
        end else if (pick < 25) begin
            send_word(CMD_CLEAR, SAMPLE_W'({$urandom, $urandom}), 1'($urandom));
        end else if (pick < 27) begin
            send_word(CMD_SCAN, SAMPLE_W'({$urandom, $urandom}), 1'($urandom));
        end
    endtask

    // One press-hold-release of a random key, with bounce and interjected words.
    task automatic key_episode(input int long_hold);
        int         row;
        logic [4:0] cols;
        int         held;
        int         rel_scans;
        if ($urandom_range(0, 7) == 0) begin
            row  = SHIFT_KEY_ROW;
            cols = {3'($urandom), 2'b10};
        end else begin
            row  = $urandom_range(0, ROWS - 1);
            cols = 5'($urandom_range(1, 31));
        end
        // Contact bounce before the key settles.
        repeat ($urandom_range(0, 3)) begin
            send_word(CMD_SCAN, key_sample($urandom_range(0, ROWS - 1), 5'($urandom)),
                      1'($urandom));
        end
        // Mostly long enough to settle, sometimes cut short.
        if ($urandom_range(0, 6) == 0) begin
            held = $urandom_range(1, predictor.debounce_count + 1);
        end else begin
            held = predictor.debounce_count + $urandom_range(1, long_hold);
        end
        repeat (held) begin
            maybe_interject();
            send_word(CMD_SCAN, key_sample(row, cols), 1'($urandom));
        end
        rel_scans = predictor.debounce_count + $urandom_range(1, 4);
        repeat (rel_scans) begin
            maybe_interject();
            send_word(CMD_SCAN, '0, 1'($urandom));
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off that backs up the block.
    initial begin
        int  stall_left;
        bit  long_stall_done;
        stall_left      = 0;
        long_stall_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (!long_stall_done && predictor.checked >= 700) begin
                long_stall_done = 1'b1;
                stall_left = 80;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (sink_gaps_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.event_valid = m_tuser[0];
            got.event_kind  = m_tuser[2:1];
            got.key_row     = m_tdata[2:0];
            got.key_column  = m_tdata[5:3];
            got.key_shifted = m_tdata[6];
            got.shift_now   = m_tdata[7];
            got.activity    = m_tdata[8];
            got.queued      = m_tdata[11:9];
            predictor.check_word(got);
        end
    end

    // Stimulus.
    initial begin
        int phase_end;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty poll, full-row press and release, shift key, shift
        // writes and clear, all at the reset settings.
        send_word(CMD_POLL, '0, 1'b0);
        repeat (4) send_word(CMD_SCAN, {SAMPLE_W{1'b1}}, 1'b1);
        send_word(CMD_POLL, {SAMPLE_W{1'b1}}, 1'b1);
        repeat (4) send_word(CMD_SCAN, '0, 1'b0);
        repeat (4) begin
            send_word(CMD_SCAN,
                      SAMPLE_W'(1) << (SHIFT_KEY_ROW * COLUMNS + SHIFT_KEY_COLUMN), 1'b0);
        end
        send_word(CMD_POLL, '0, 1'b0);
        send_word(CMD_POLL, '0, 1'b1);
        repeat (4) send_word(CMD_SCAN, '0, 1'b0);
        send_word(CMD_POLL, '0, 1'b0);
        send_word(CMD_SET_SHIFT, '0, 1'b0);
        send_word(CMD_SET_SHIFT, {SAMPLE_W{1'b1}}, 1'b1);
        send_word(CMD_CLEAR, {SAMPLE_W{1'b1}}, 1'b1);
        send_word(CMD_POLL, '0, 1'b0);

        // Random phases, each under its own register settings.
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: ;
                1: load_settings(4'd1, 16'd100, 16'd300, 16'd200);
                2: load_settings(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: begin
                    // Key left settled at the highest debounce count, then the
                    // count is lowered below the settle counter.
                    hold_key(3, 5'b00100, 20);
                    load_settings(4'd0, 16'd0, 16'd0, 16'hFFFF);
                    hold_key(3, 5'b00100, 5);
                end
                4: load_settings(4'd2, 16'd0, 16'd500, 16'd400);
                5: load_settings(4'd4, 16'd1000, 16'd60000, 16'd0);
                default: load_settings(4'($urandom_range(1, 6)), 16'($urandom_range(1, 300)),
                                       16'($urandom_range(0, 2000)),
                                       16'($urandom_range(0, 1500)));
            endcase
            src_gaps_on  = (p != 2 && p != 8);
            sink_gaps_on = (p != 2 && p != 8);
            phase_end = 25 + 200 * (p + 1);
            while (words_sent < phase_end) begin
                key_episode((p == 0 || p == 5) ? 70 : 30);
            end
        end

        wait_idle();
        repeat (10) @(negedge aclk);
        $display("Ran %0d words under %0d register settings; %0d results checked.",
                 words_sent, settings_used, predictor.checked);
        $display("Queued %0d presses, %0d releases, %0d repeats; %0d dropped on full ring;",
                 predictor.presses, predictor.releases, predictor.repeats, predictor.drops);
        $display("%0d/%0d polls hit/empty.", predictor.polls_hit, predictor.polls_empty);
        if (predictor.errors == 0 && predictor.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #4000000;
        $display("%0t: timed out with %0d results outstanding", $time, predictor.pending());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== keypad_scan_debounce_repeat.f =====
hdl/kpsdr_pkg.sv
hdl/kpsdr_front.sv
hdl/kpsdr_queue.sv
hdl/kpsdr_back.sv
hdl/keypad_scan_debounce_repeat.sv
bench/keypad_scan_debounce_repeat_tb.sv
